[hdl/rfa_pkg.sv]
// Shared types, constants and commands for the rational fraction ALU.
package rfa_pkg;
  localparam int OW = 16;
  localparam int MW = 2 * OW + 1;
  localparam int NW = 32;
  localparam int DW = 30;
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_INV = 3'd3,
    CMD_RED = 3'd4,
    CMD_EQ  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_sel_den;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic direct;
    logic zero_den;
    logic gcd_done;
    logic div_done;
  } sts_t;
endpackage

[hdl/rfa_ctrl.sv]
// Sequencer for the rational fraction ALU.
module rfa_ctrl import rfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl,
  input  sts_t sts
);
  state_t state, state_next;
  logic out_busy, out_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_busy <= 1'b0;
    end else begin
      state <= state_next;
      out_busy <= out_busy_next;
    end
  end

  assign out_valid = out_busy;

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_busy_next = out_busy && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        ctl.sum = 1'b1;
        state_next = ST_GCD;
      end
      ST_GCD: begin
        if (sts.direct || sts.zero_den) state_next = ST_OUT;
        else if (sts.gcd_done) begin
          ctl.div_init = 1'b1;
          state_next = ST_DIVN;
        end else ctl.gcd_step = 1'b1;
      end
      ST_DIVN: begin
        if (sts.div_done) begin
          ctl.div_init = 1'b1;
          ctl.div_sel_den = 1'b1;
          state_next = ST_DIVD;
        end else ctl.div_step = 1'b1;
      end
      ST_DIVD: begin
        ctl.div_sel_den = 1'b1;
        if (sts.div_done) state_next = ST_OUT;
        else ctl.div_step = 1'b1;
      end
      ST_OUT: begin
        if (!out_busy || out_ready) begin
          ctl.fin = 1'b1;
          out_busy_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_SUM) ctl.gcd_init = 1'b1;
  end

  a_fin_only_out: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |-> state == ST_OUT) else $error("finish outside output state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |=> out_valid) else $error("finish without valid");
endmodule

[hdl/rfa_dp.sv]
// Datapath: cross products, binary gcd and restoring division by the gcd.
module rfa_dp import rfa_pkg::*; (
  input  logic clk,
  input  logic [2:0] command,
  input  logic signed [OW-1:0] a_num,
  input  logic signed [OW-1:0] a_den,
  input  logic signed [OW-1:0] b_num,
  input  logic signed [OW-1:0] b_den,
  input  ctl_t ctl,
  output sts_t sts,
  output logic signed [NW-1:0] res_num,
  output logic [DW-1:0] res_den,
  output logic is_equal,
  output logic is_zero,
  output logic div_error
);
  logic [2:0] cmd;
  logic [OW:0] an, ad, bn, bd;
  logic ans, ads, bns, bds;
  logic eq;
  logic [MW-1:0] p1, p2, pd;
  logic p1s, p2s, pds;
  logic [MW-1:0] nm, dn;
  logic nms, dns;
  logic [MW-1:0] gx, gy;
  logic [CW-1:0] gsh;
  logic [MW-1:0] g;
  logic [MW-1:0] q, rem, dvd;
  logic [CW-1:0] cnt;
  logic [MW-1:0] qn;
  logic direct;

  function automatic logic [OW:0] mag(input logic [OW-1:0] v);
    return v[OW-1] ? (OW+1)'(-$signed({v[OW-1], v})) : {1'b0, v};
  endfunction

  logic [MW-1:0] s_mag;
  logic s_neg;
  logic [MW-1:0] gd;
  logic [MW:0] trial;
  logic [MW-1:0] rden;
  logic rneg;

  always_comb begin
    if (p1s == p2s) begin
      s_mag = p1 + p2; s_neg = p1s;
    end else if (p1 >= p2) begin
      s_mag = p1 - p2; s_neg = p1s;
    end else begin
      s_mag = p2 - p1; s_neg = p2s;
    end
    gd = (gx > gy) ? gx - gy : gy - gx;
    g = gx << gsh;
    trial = {rem, dvd[MW-1]} - {1'b0, g};
  end

  assign direct = (cmd != CMD_ADD) && (cmd != CMD_SUB) && (cmd != CMD_MUL) &&
                  (cmd != CMD_INV) && (cmd != CMD_RED);
  assign sts.direct = direct;
  assign sts.zero_den = (dn == '0);
  assign sts.gcd_done = (gx == gy) || (gy == '0) || (gx == '0);
  assign sts.div_done = (cnt == '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= command;
      an <= mag(a_num); ans <= a_num[OW-1];
      ad <= mag(a_den); ads <= a_den[OW-1];
      bn <= mag(b_num); bns <= b_num[OW-1] ^ (command == CMD_SUB);
      bd <= mag(b_den); bds <= b_den[OW-1];
      eq <= ((a_num == '0) && (b_num == '0)) || ((a_num == b_num) && (a_den == b_den));
    end
    if (ctl.mul) begin
      if (cmd == CMD_MUL) begin
        p1 <= MW'(an * bn); p1s <= ans ^ bns;
      end else begin
        p1 <= MW'(an * bd); p1s <= ans ^ bds;
      end
      p2 <= MW'(bn * ad); p2s <= bns ^ ads;
      pd <= MW'(ad * bd); pds <= ads ^ bds;
    end
    if (ctl.sum) begin
      unique case (cmd)
        CMD_ADD, CMD_SUB: begin nm <= s_mag; nms <= s_neg; dn <= pd; dns <= pds; end
        CMD_MUL: begin nm <= p1; nms <= p1s; dn <= pd; dns <= pds; end
        CMD_INV: begin nm <= MW'(ad); nms <= ads; dn <= MW'(an); dns <= ans; end
        default: begin nm <= MW'(an); nms <= ans; dn <= MW'(ad); dns <= ads; end
      endcase
    end
    if (ctl.gcd_init) begin
      gsh <= '0;
      unique case (cmd)
        CMD_ADD, CMD_SUB: begin gx <= s_mag; gy <= pd; end
        CMD_MUL: begin gx <= p1; gy <= pd; end
        CMD_INV: begin gx <= MW'(ad); gy <= MW'(an); end
        default: begin gx <= MW'(an); gy <= MW'(ad); end
      endcase
    end else if (ctl.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; gsh <= gsh + 1'b1;
      end else if (!gx[0]) gx <= gx >> 1;
      else if (!gy[0]) gy <= gy >> 1;
      else if (gx > gy) gx <= gd;
      else gy <= gd;
    end else if (ctl.div_init && !ctl.div_sel_den) begin
      if (gx == '0) gx <= gy;
    end
    if (ctl.div_init) begin
      dvd <= ctl.div_sel_den ? dn : nm;
      rem <= '0;
      q <= '0;
      cnt <= CW'(MW);
      if (ctl.div_sel_den) qn <= q;
    end else if (ctl.div_step) begin
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (!trial[MW]) begin
        rem <= trial[MW-1:0]; q <= {q[MW-2:0], 1'b1};
      end else begin
        rem <= {rem[MW-2:0], dvd[MW-1]}; q <= {q[MW-2:0], 1'b0};
      end
    end
    if (ctl.fin) begin
      is_equal <= 1'b0; res_num <= '0; res_den <= '0; is_zero <= 1'b0; div_error <= 1'b0;
      if (cmd == CMD_EQ) is_equal <= eq;
      else if (!direct) begin
        if (dn == '0) div_error <= 1'b1;
        else begin
          res_num <= rneg ? NW'(-qn) : NW'(qn);
          res_den <= (rden > MW'({DW{1'b1}})) ? {DW{1'b1}} : DW'(rden);
          is_zero <= (qn == '0);
        end
      end
    end
  end

  assign rden = q;
  assign rneg = (qn != '0) && (nms != dns);

  a_gcd_nonzero: assert property (@(posedge clk)
    ctl.div_step |-> g != '0) else $error("divide by zero gcd");
  a_div_count: assert property (@(posedge clk)
    ctl.div_init |=> cnt == CW'(MW)) else $error("division count not loaded");
  a_flags_exclusive: assert property (@(posedge clk)
    ctl.fin |=> !(div_error && is_zero)) else $error("error and zero flags together");
endmodule

[hdl/rational_fraction_alu.sv]
// Top level of the rational fraction ALU.
// Flow: compare, unused commands and zero denominators go from the gcd state straight
// to the output state; all other commands run the binary gcd loop and then two 33-step
// restoring divisions, first of the numerator and then of the denominator.
// Throughput: one item at a time, the next accepted in the cycle after the result is
// loaded; a finished result waits in the output register.
// Reset: synchronous rst returns the sequencer to idle and drops out_valid.
module rational_fraction_alu import rfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] command,
  input  logic signed [OW-1:0] a_num,
  input  logic signed [OW-1:0] a_den,
  input  logic signed [OW-1:0] b_num,
  input  logic signed [OW-1:0] b_den,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [NW-1:0] res_num,
  output logic [DW-1:0] res_den,
  output logic is_equal,
  output logic is_zero,
  output logic div_error
);
  ctl_t ctl;
  sts_t sts;

  rfa_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .ctl, .sts);
  rfa_dp u_dp (.clk, .command, .a_num, .a_den, .b_num, .b_den, .ctl, .sts,
    .res_num, .res_den, .is_equal, .is_zero, .div_error);
endmodule
